@@ design/pas_pkg.sv @@
// shared constants and types for the polar angle sort median block
`timescale 1ns / 1ps
package pas_pkg;
    localparam int MAX_POINTS = 16384;
    localparam int COORD_BITS = 32;
    localparam int ADDR_W     = $clog2(MAX_POINTS);
    localparam int CNT_W      = ADDR_W + 1;
    localparam int NUM_W      = 15;

    typedef struct packed {
        logic [CNT_W-1:0]             count;
        logic signed [COORD_BITS-1:0] pivot_x;
        logic signed [COORD_BITS-1:0] pivot_y;
        logic [ADDR_W-1:0]            pivot_num;
        logic                         lost;
    } job_t;

    typedef enum logic [1:0] {
        CLS_PIVOT,
        CLS_FINITE,
        CLS_INFINITE
    } cls_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_CRD,
        B_CCAP,
        B_SCAN,
        B_DRAIN,
        B_CHECK,
        B_DONE
    } back_state_t;
endpackage

@@ design/polar_angle_sort_median.sv @@
// top level of the polar angle sort median block
`timescale 1ns / 1ps
// usage:
// points enter on the s_ channel, one point per beat, one beat per cycle while
// loading; s_tlast marks the final point of a set. points past capacity are
// dropped and reported through the overflow bit.
// after the last beat the sorter looks for the point at sorted position n/2 by
// counting, for each candidate in input order, how many points sort ahead of
// it. each candidate takes a pass over all n points through the single ram read
// port and the cross product pipeline, so a set takes up to n such passes,
// far fewer when the median shows up early in input order.
// s_tready stays low from the last beat of a set until its result has left the
// sorter, since the next set reuses the point memory.
// one result beat per set on the m_ channel; it is held in an output register,
// and a stalled receiver only delays the sorter handing over the next result.
// aresetn clears all control state and drops any partly loaded set; the point
// memory needs no clearing.
module polar_angle_sort_median (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // px, py
    input  logic        s_tlast,   // last_point
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // first_number, median_number, overflow, zero pad
);
    import pas_pkg::*;

    logic                    push, pop, q_valid;
    job_t                    push_job, job;
    logic                    wr_en, rd_en;
    logic [ADDR_W-1:0]       wr_addr, rd_addr;
    logic [2*COORD_BITS-1:0] wr_data, rd_data;
    logic [NUM_W-1:0]        first_number, median_number;
    logic                    overflow;

    pas_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_tvalid),
        .s_ready    (s_tready),
        .px         (s_tdata[31:0]),
        .py         (s_tdata[63:32]),
        .last_point (s_tlast),
        .q_busy     (q_valid),
        .push       (push),
        .job        (push_job),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data)
    );

    pas_ram #(
        .WIDTH (2 * COORD_BITS),
        .DEPTH (MAX_POINTS)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    pas_job_q u_q (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_job  (push_job),
        .pop       (pop),
        .job_valid (q_valid),
        .job       (job)
    );

    pas_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .job_valid     (q_valid),
        .job           (job),
        .pop           (pop),
        .rd_en         (rd_en),
        .rd_addr       (rd_addr),
        .rd_data       (rd_data),
        .m_valid       (m_tvalid),
        .m_ready       (m_tready),
        .first_number  (first_number),
        .median_number (median_number),
        .overflow      (overflow)
    );

    assign m_tdata = {1'b0, overflow, median_number, first_number};

`ifndef ASSERT_OFF
    a_load_blocked: assert property (@(posedge aclk) disable iff (!aresetn)
        q_valid |-> !s_tready) else $error("loader open while a set is pending");
    a_pop_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |=> !q_valid) else $error("job still pending after result");
    a_first_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (first_number != '0) && (median_number != '0))
        else $error("zero point number in result");
`endif
endmodule

@@ design/pas_ram.sv @@
// generic single write port ram with registered read
`timescale 1ns / 1ps
module pas_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule

@@ design/pas_front.sv @@
// point loader: stores points and tracks the pivot
`timescale 1ns / 1ps
module pas_front (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [pas_pkg::COORD_BITS-1:0] px,
    input  logic signed [pas_pkg::COORD_BITS-1:0] py,
    input  logic                              last_point,
    input  logic                              q_busy,
    output logic                              push,
    output pas_pkg::job_t                     job,
    output logic                              wr_en,
    output logic [pas_pkg::ADDR_W-1:0]        wr_addr,
    output logic [2*pas_pkg::COORD_BITS-1:0]  wr_data
);
    import pas_pkg::*;

    logic [CNT_W-1:0]             count_reg, count_next;
    logic signed [COORD_BITS-1:0] pivot_x_reg, pivot_x_next;
    logic signed [COORD_BITS-1:0] pivot_y_reg, pivot_y_next;
    logic [ADDR_W-1:0]            pivot_num_reg, pivot_num_next;
    logic                         lost_reg, lost_next;
    logic                         accept, room, take_pivot;

    assign s_ready = !q_busy;
    assign accept  = s_valid && s_ready;
    assign room    = count_reg < CNT_W'(MAX_POINTS);
    assign take_pivot = (count_reg == '0) || (px < pivot_x_reg)
                        || ((px == pivot_x_reg) && (py < pivot_y_reg));

    assign wr_en   = accept && room;
    assign wr_addr = count_reg[ADDR_W-1:0];
    assign wr_data = {py, px};

    always_comb begin
        count_next     = count_reg;
        pivot_x_next   = pivot_x_reg;
        pivot_y_next   = pivot_y_reg;
        pivot_num_next = pivot_num_reg;
        lost_next      = lost_reg;
        if (accept) begin
            if (room) begin
                count_next = count_reg + 1'b1;
                if (take_pivot) begin
                    pivot_x_next   = px;
                    pivot_y_next   = py;
                    pivot_num_next = count_reg[ADDR_W-1:0];
                end
            end else begin
                lost_next = 1'b1;
            end
        end
    end

    assign push = accept && last_point;
    assign job  = '{count: count_next, pivot_x: pivot_x_next, pivot_y: pivot_y_next,
                    pivot_num: pivot_num_next, lost: lost_next};

    always_ff @(posedge aclk) begin
        if (!aresetn || push) begin
            count_reg     <= '0;
            pivot_x_reg   <= '0;
            pivot_y_reg   <= '0;
            pivot_num_reg <= '0;
            lost_reg      <= 1'b0;
        end else begin
            count_reg     <= count_next;
            pivot_x_reg   <= pivot_x_next;
            pivot_y_reg   <= pivot_y_next;
            pivot_num_reg <= pivot_num_next;
            lost_reg      <= lost_next;
        end
    end
endmodule

@@ design/pas_job_q.sv @@
// one-entry job queue between loader and sorter
`timescale 1ns / 1ps
module pas_job_q (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  pas_pkg::job_t push_job,
    input  logic          pop,
    output logic          job_valid,
    output pas_pkg::job_t job
);
    import pas_pkg::*;

    logic valid_reg;
    job_t job_reg;

    assign job_valid = valid_reg;
    assign job       = job_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (push) begin
            valid_reg <= 1'b1;
        end else if (pop) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            job_reg <= push_job;
        end
    end
endmodule

@@ design/pas_back.sv @@
// rank search: finds the point at sorted position n/2 by counting predecessors
`timescale 1ns / 1ps
module pas_back (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             job_valid,
    input  pas_pkg::job_t                    job,
    output logic                             pop,
    output logic                             rd_en,
    output logic [pas_pkg::ADDR_W-1:0]       rd_addr,
    input  logic [2*pas_pkg::COORD_BITS-1:0] rd_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [pas_pkg::NUM_W-1:0]        first_number,
    output logic [pas_pkg::NUM_W-1:0]        median_number,
    output logic                             overflow
);
    import pas_pkg::*;
    localparam int W = COORD_BITS;

    back_state_t state_reg, state_next;
    logic [ADDR_W-1:0] cand_reg;
    logic [CNT_W-1:0]  j_reg, rank_reg;
    cls_t              cand_cls_reg;
    logic [W-1:0]      cand_dx_reg, cand_ady_reg;
    logic              cand_neg_reg;

    logic              v1_reg, v2_reg, v3_reg;
    logic [ADDR_W-1:0] j1_reg, j2_reg, j3_reg;
    cls_t              cls2_reg, cls3_reg;
    logic [W-1:0]      dx2_reg, ady2_reg;
    logic              neg2_reg, neg3_reg;
    logic [2*W-1:0]    m1_reg, m2_reg;

    logic              m_valid_reg;
    logic [NUM_W-1:0]  first_reg, median_reg;
    logic              over_reg;

    logic              issue, cap, check_hit, load_out;
    logic [W:0]        dx_full, dy_full, ady_full;
    cls_t              rd_cls;
    logic              n1, n2, lt, eq, ahead;

    // differences from the pivot for the word just read
    assign dx_full  = {rd_data[W-1], rd_data[W-1:0]} - {job.pivot_x[W-1], job.pivot_x};
    assign dy_full  = {rd_data[2*W-1], rd_data[2*W-1:W]} - {job.pivot_y[W-1], job.pivot_y};
    assign ady_full = dy_full[W] ? (~dy_full + 1'b1) : dy_full;

    always_comb begin
        if ((cap ? cand_reg : j1_reg) == job.pivot_num) begin
            rd_cls = CLS_PIVOT;
        end else if (rd_data[W-1:0] == job.pivot_x) begin
            rd_cls = CLS_INFINITE;
        end else begin
            rd_cls = CLS_FINITE;
        end
    end

    // slope order of scanned point against the candidate
    assign n1 = neg3_reg && (m1_reg != '0);
    assign n2 = cand_neg_reg && (m2_reg != '0);
    assign lt = (n1 != n2) ? n1 : (n1 ? (m1_reg > m2_reg) : (m1_reg < m2_reg));
    assign eq = (n1 == n2) && (m1_reg == m2_reg);
    always_comb begin
        if (cls3_reg != cand_cls_reg) begin
            ahead = cls3_reg < cand_cls_reg;
        end else if (cand_cls_reg == CLS_FINITE) begin
            ahead = lt || (eq && (j3_reg < cand_reg));
        end else begin
            ahead = j3_reg < cand_reg;
        end
    end

    assign check_hit = rank_reg == (job.count >> 1);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:  if (job_valid) state_next = B_CRD;
            B_CRD:   state_next = B_CCAP;
            B_CCAP:  state_next = B_SCAN;
            B_SCAN:  if (j_reg == job.count - 1'b1) state_next = B_DRAIN;
            B_DRAIN: if (!v1_reg && !v2_reg && !v3_reg) state_next = B_CHECK;
            B_CHECK: state_next = check_hit ? B_DONE : B_CRD;
            B_DONE:  if (!m_valid_reg || m_ready) state_next = B_IDLE;
            default: state_next = B_IDLE;
        endcase
    end

    always_comb begin
        issue    = 1'b0;
        cap      = 1'b0;
        load_out = 1'b0;
        rd_en    = 1'b0;
        rd_addr  = cand_reg;
        unique case (state_reg)
            B_CRD: begin
                rd_en = 1'b1;
            end
            B_CCAP: begin
                cap = 1'b1;
            end
            B_SCAN: begin
                issue   = 1'b1;
                rd_en   = 1'b1;
                rd_addr = j_reg[ADDR_W-1:0];
            end
            B_DONE: begin
                load_out = !m_valid_reg || m_ready;
            end
            default: begin
            end
        endcase
    end

    assign pop = load_out;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= B_IDLE;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            v1_reg    <= issue;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == B_IDLE) begin
            cand_reg <= '0;
        end else if (state_reg == B_CHECK && !check_hit) begin
            cand_reg <= cand_reg + 1'b1;
        end
        if (cap) begin
            cand_cls_reg <= rd_cls;
            cand_dx_reg  <= dx_full[W-1:0];
            cand_ady_reg <= ady_full[W-1:0];
            cand_neg_reg <= dy_full[W];
            j_reg        <= '0;
            rank_reg     <= '0;
        end else begin
            if (issue) begin
                j_reg <= j_reg + 1'b1;
            end
            if (v3_reg && ahead) begin
                rank_reg <= rank_reg + 1'b1;
            end
        end
        j1_reg   <= j_reg[ADDR_W-1:0];
        j2_reg   <= j1_reg;
        cls2_reg <= rd_cls;
        dx2_reg  <= dx_full[W-1:0];
        ady2_reg <= ady_full[W-1:0];
        neg2_reg <= dy_full[W];
        j3_reg   <= j2_reg;
        cls3_reg <= cls2_reg;
        neg3_reg <= neg2_reg;
        m1_reg   <= (2*W)'(ady2_reg) * (2*W)'(cand_dx_reg);
        m2_reg   <= (2*W)'(cand_ady_reg) * (2*W)'(dx2_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            first_reg  <= NUM_W'(job.pivot_num) + 1'b1;
            median_reg <= NUM_W'(cand_reg) + 1'b1;
            over_reg   <= job.lost;
        end
    end

    assign m_valid       = m_valid_reg;
    assign first_number  = first_reg;
    assign median_number = median_reg;
    assign overflow      = over_reg;
endmodule
